>>> hdl/dfla_pkg.sv
package dfla_pkg;

	localparam int POOL_SIZE = 768;
	localparam int IDX_W     = 10;
	localparam int LINK_AW   = $clog2(POOL_SIZE);
	localparam int FRESH_W   = $clog2(POOL_SIZE + 1);

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] free_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] alloc_index;
		logic             exhausted;
	} res_t;

	typedef struct packed {
		logic               we;
		logic [LINK_AW-1:0] waddr;
		logic [IDX_W-1:0]   wdata;
		logic               re;
		logic [LINK_AW-1:0] raddr;
	} link_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

>>> hdl/dfla_link_ram.sv
module dfla_link_ram #(
	parameter int DEPTH = 768,
	parameter int WIDTH = 10,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/dfla_ctrl.sv
module dfla_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  dfla_pkg::req_t              req,
	output logic                        strobe,
	output dfla_pkg::res_t              result,
	output dfla_pkg::link_req_t         link_req,
	input  logic [dfla_pkg::IDX_W-1:0]  link_rdata
);

	dfla_pkg::state_t state_q, state_d;
	logic [dfla_pkg::IDX_W-1:0]   head_q;
	logic [dfla_pkg::FRESH_W-1:0] fresh_q;
	logic                         strobe_q;
	dfla_pkg::res_t               result_q;

	logic accept, is_alloc, free_ok, head_ok, fresh_ok;

	assign accept   = start && (state_q == dfla_pkg::ST_IDLE);
	assign is_alloc = (req.req_type == dfla_pkg::REQ_ALLOC);
	assign free_ok  = (req.free_index != '0) && (32'(req.free_index) < dfla_pkg::POOL_SIZE);
	assign head_ok  = (head_q != '0) && (32'(head_q) < dfla_pkg::POOL_SIZE);
	assign fresh_ok = 32'(fresh_q) < dfla_pkg::POOL_SIZE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dfla_pkg::ST_IDLE: begin
				if (accept && is_alloc) begin
					state_d = dfla_pkg::ST_POP;
				end
			end
			dfla_pkg::ST_POP: state_d = dfla_pkg::ST_IDLE;
			default: state_d = dfla_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy           = 1'b0;
		link_req.we    = 1'b0;
		link_req.re    = 1'b0;
		link_req.waddr = dfla_pkg::LINK_AW'(req.free_index);
		link_req.wdata = head_q;
		link_req.raddr = dfla_pkg::LINK_AW'(head_q);
		case (state_q)
			dfla_pkg::ST_IDLE: begin
				link_req.we = accept && !is_alloc && free_ok;
				link_req.re = accept && is_alloc;
			end
			dfla_pkg::ST_POP: busy = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dfla_pkg::ST_IDLE;
			head_q   <= '0;
			fresh_q  <= dfla_pkg::FRESH_W'(1);
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == dfla_pkg::ST_POP);
			if (link_req.we) begin
				head_q <= req.free_index;
			end
			if (state_q == dfla_pkg::ST_POP) begin
				if (head_ok) begin
					head_q <= link_rdata;
				end else if (fresh_ok) begin
					fresh_q <= fresh_q + dfla_pkg::FRESH_W'(1);
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == dfla_pkg::ST_POP) begin
			if (head_ok) begin
				result_q.alloc_index <= head_q;
				result_q.exhausted   <= 1'b0;
			end else if (fresh_ok) begin
				result_q.alloc_index <= dfla_pkg::IDX_W'(fresh_q);
				result_q.exhausted   <= 1'b0;
			end else begin
				result_q.alloc_index <= '0;
				result_q.exhausted   <= 1'b1;
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> hdl/descriptor_free_list_allocator_unit.sv
// Descriptor index allocator: linked free list with a bump counter.
//
// Command channel: drive start with req; the item is taken at a rising edge
// where start is high and busy is low. req_type selects allocate or free.
// A free pushes free_index onto the list head and gives no
// result; index 0 or an index beyond the pool is dropped. Busy stays low,
// so frees can be issued every cycle.
// An allocate raises busy for one cycle while the head's link is read from
// the link RAM (synchronous read); the result appears with strobe
// for exactly one cycle, registered at the end of the pop state. A new item
// may be started in that strobe cycle; busy holds off any new item until
// the pop state is done.
// Result: alloc_index, or 0 with exhausted set when the list is empty and
// every fresh index has been handed out.
// Reset (arst_n low): list empty, fresh counter at 1, no strobe. The link
// RAM is not cleared; links are always written before they are used.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module descriptor_free_list_allocator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dfla_pkg::req_t req,
	output logic           strobe,
	output dfla_pkg::res_t result
);

	dfla_pkg::link_req_t        link_req;
	logic [dfla_pkg::IDX_W-1:0] link_rdata;

	dfla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.strobe     (strobe),
		.result     (result),
		.link_req   (link_req),
		.link_rdata (link_rdata)
	);

	dfla_link_ram #(
		.DEPTH (dfla_pkg::POOL_SIZE),
		.WIDTH (dfla_pkg::IDX_W)
	) u_link_ram (
		.clk   (clk),
		.we    (link_req.we),
		.waddr (link_req.waddr),
		.wdata (link_req.wdata),
		.re    (link_req.re),
		.raddr (link_req.raddr),
		.rdata (link_rdata)
	);

endmodule

>>> hdl/dfla_checker.sv
module dfla_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input dfla_pkg::req_t req,
	input logic           strobe,
	input dfla_pkg::res_t result
);

	// allocate raises busy and holds off the next item
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == dfla_pkg::REQ_ALLOC) |=> busy)
		else $error("allocate did not raise busy");

	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy) && $past(start && !busy && req.req_type == dfla_pkg::REQ_ALLOC, 2))
		else $error("strobe without a matching allocate");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("strobe while busy");

	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.exhausted |-> result.alloc_index == '0)
		else $error("exhausted result with nonzero index");

endmodule

bind descriptor_free_list_allocator_unit dfla_checker u_dfla_checker (.*);

>>> dv/descriptor_free_list_allocator_unit_tb.sv
`timescale 1ns / 100ps

module descriptor_free_list_allocator_unit_tb;

	import dfla_pkg::*;

	typedef struct {
		logic             kind;
		logic [IDX_W-1:0] idx;
		bit               typed;
		logic [IDX_W-1:0] want_idx;
		bit               want_exh;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic strobe;
	res_t result;

	// pool model
	logic [IDX_W-1:0] pool_head;
	int               pool_fresh;
	logic [IDX_W-1:0] pool_link [POOL_SIZE];

	res_t             alloc_expect_q [$];
	logic [IDX_W-1:0] held_q [$];

	int errors      = 0;
	int n_items     = 0;
	int n_alloc     = 0;
	int n_free      = 0;
	int n_exh       = 0;
	int n_dropped   = 0;
	int idle_cycles = 0;

	// typed expectations only where obvious: after reset and at the extremes
	dir_row_t dir_tbl [20] = '{
		'{REQ_ALLOC, 10'd0,    1'b1, 10'd1,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b1, 10'd2,   1'b0},
		'{REQ_FREE,  10'd0,    1'b0, 10'd0,   1'b0},
		'{REQ_FREE,  10'd768,  1'b0, 10'd0,   1'b0},
		'{REQ_FREE,  10'd1023, 1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b1, 10'd3,   1'b0},
		'{REQ_FREE,  10'd2,    1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b0, 10'd0,   1'b0},
		'{REQ_FREE,  10'd767,  1'b0, 10'd0,   1'b0},
		'{REQ_FREE,  10'd1,    1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b1, 10'd767, 1'b0},
		'{REQ_ALLOC, 10'd0,    1'b0, 10'd0,   1'b0},
		'{REQ_FREE,  10'd512,  1'b0, 10'd0,   1'b0},
		'{REQ_FREE,  10'd341,  1'b0, 10'd0,   1'b0},
		'{REQ_FREE,  10'd682,  1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b0, 10'd0,   1'b0},
		'{REQ_ALLOC, 10'd0,    1'b0, 10'd0,   1'b0}
	};

	descriptor_free_list_allocator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit pool_apply(input req_t r, output res_t res);
		res = '0;
		if (r.req_type == REQ_FREE) begin
			if (r.free_index != '0 && r.free_index < POOL_SIZE) begin
				pool_link[r.free_index] = pool_head;
				pool_head = r.free_index;
			end else begin
				n_dropped++;
			end
			return 1'b0;
		end
		if (pool_head != '0 && pool_head < POOL_SIZE) begin
			res.alloc_index = pool_head;
			pool_head = pool_link[pool_head];
		end else if (pool_fresh < POOL_SIZE) begin
			res.alloc_index = pool_fresh[IDX_W-1:0];
			pool_fresh++;
		end else begin
			res.exhausted = 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic send_item(input req_t r, input bit typed, input res_t typed_res);
		res_t got;
		bit   has_res;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		has_res = pool_apply(r, got);
		n_items++;
		if (has_res) begin
			n_alloc++;
			if (got.exhausted) n_exh++;
			else held_q.push_back(got.alloc_index);
			alloc_expect_q.push_back(typed ? typed_res : got);
		end else begin
			n_free++;
		end
	endtask

	task automatic idle_gap(input int pct);
		int g;
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			g = 1;
			while (g < 40 && $urandom_range(99) < pct) g++;
			repeat (g) @(posedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && strobe) begin
			if (alloc_expect_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual index %0d exhausted %0b",
					$time, result.alloc_index, result.exhausted);
				errors++;
			end else begin
				want = alloc_expect_q.pop_front();
				if (result.alloc_index !== want.alloc_index) begin
					$display("%0t: alloc_index mismatch: expected %0d, actual %0d",
						$time, want.alloc_index, result.alloc_index);
					errors++;
				end
				if (result.exhausted !== want.exhausted) begin
					$display("%0t: exhausted mismatch: expected %0b, actual %0b",
						$time, want.exhausted, result.exhausted);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any accepted item or result
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= 4000) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		req_t r;
		int   n;
		int   pct;
		int   draw;
		int   k;
		int   gap_pct [3];
		gap_pct = '{0, 73, 30};
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		pool_head  = '0;
		pool_fresh = 1;
		foreach (pool_link[i]) pool_link[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i]) begin
			send_item(req_t'{dir_tbl[i].kind, dir_tbl[i].idx}, dir_tbl[i].typed,
				res_t'{dir_tbl[i].want_idx, dir_tbl[i].want_exh});
			idle_gap(30);
		end

		// mostly allocates first, then mixed traffic with double frees
		n = 0;
		while (n < 480) begin
			pct  = gap_pct[(n / 120) % 3];
			draw = $urandom_range(99);
			r.req_type   = REQ_ALLOC;
			r.free_index = 10'($urandom_range(1023));
			if (draw < 4) begin
				r.req_type   = REQ_FREE;
				r.free_index = $urandom_range(1) ? '0 : 10'($urandom_range(1023, POOL_SIZE));
			end else if (n < 300) begin
				if (draw >= 84 && held_q.size() != 0) begin
					k = $urandom_range(held_q.size() - 1);
					r.req_type   = REQ_FREE;
					r.free_index = held_q[k];
					held_q.delete(k);
				end
			end else begin
				if (draw < 7) begin
					r.req_type   = REQ_FREE;
					r.free_index = (pool_head != '0) ? pool_head
						: 10'($urandom_range(POOL_SIZE - 1, 1));
				end else if (draw < 11) begin
					r.req_type   = REQ_FREE;
					r.free_index = 10'($urandom_range(POOL_SIZE - 1, 1));
				end else if (draw >= 55 && held_q.size() != 0) begin
					k = $urandom_range(held_q.size() - 1);
					r.req_type   = REQ_FREE;
					r.free_index = held_q[k];
					held_q.delete(k);
				end
			end
			send_item(r, 1'b0, '0);
			n++;
			idle_gap(pct);
		end
		start <= 1'b0;

		while (alloc_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Ran %0d items: %0d allocates, %0d of them exhausted; %0d frees, %0d dropped.",
			n_items, n_alloc, n_exh, n_free, n_dropped);
		$display("Pool grown from fresh indices, then reused with double frees and idle gaps.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
